>>> rtl/imhq_pkg.sv
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared types and constants for the indexed min-heap queue.
// ----------------------------------------------------------------------------
package imhq_pkg;

   localparam int HEAP_DEPTH_DEF    = 1024;
   localparam int KEY_SPACE_DEF     = 1024;
   localparam int PRIORITY_BITS_DEF = 32;

   localparam int KEY_W   = 10;
   localparam int KIND_W  = 3;
   localparam int STAT_W  = 3;
   localparam int TOTAL_W = 11;
   localparam int PRIO_W  = 32;

   localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_UPDATE     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE_MIN = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REMOVE_KEY = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY      = 3'd1;
   localparam logic [STAT_W-1:0] STAT_DUPLICATE  = 3'd2;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_FULL       = 3'd4;
   localparam logic [STAT_W-1:0] STAT_DIRECT_OFF = 3'd5;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_FIND,
      ST_FOUND,
      ST_LAST,
      ST_UP,
      ST_UP_CMP,
      ST_DOWN,
      ST_DOWN_L,
      ST_DOWN_R,
      ST_DONE
   } state_type;

endpackage

>>> rtl/imhq_ram.sv
// ----------------------------------------------------------------------------
// imhq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/indexed_min_heap_queue_top.sv
// ----------------------------------------------------------------------------
// indexed_min_heap_queue_top
// Indexed binary min-heap of (key, priority) words with a key position table.
//
//   channel | direction | handshake              | word
//   req     | in        | req_valid / req_stall  | kind, key, priority_req
//   rsp     | out       | rsp_valid / rsp_stall  | status, total, top entry
//   csr     | in        | csr_valid / csr_ready  | direct_mode
//
// One request at a time: each level walked up passes ST_UP and ST_UP_CMP, and each
// level walked down passes ST_DOWN, ST_DOWN_L and, with a right child, ST_DOWN_R,
// set by the single read port of the heap RAM.
// Clear sweeps the position table.
// After reset the same sweep runs with req_stall high.
// A result waiting in the output register stalls only the end of the next request.
// ----------------------------------------------------------------------------
module indexed_min_heap_queue_top
   import imhq_pkg::*;
#(
   parameter int HEAP_DEPTH    = HEAP_DEPTH_DEF,
   parameter int KEY_SPACE     = KEY_SPACE_DEF,
   parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [PRIO_W-1:0]  req_priority_req,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [TOTAL_W-1:0] rsp_entry_total,
   output logic               rsp_top_valid,
   output logic [KEY_W-1:0]   rsp_top_key,
   output logic [PRIO_W-1:0]  rsp_top_priority,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_direct_mode
);

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int KA = $clog2(KEY_SPACE);
   localparam int PB = PRIORITY_BITS;
   localparam int EW = KEY_W + PB;
   localparam int TW = AW + 1;
   localparam int XW = AW + 2;

   function automatic logic key_ok(input logic [KEY_W-1:0] k);
      return 17'(k) < 17'(KEY_SPACE);
   endfunction

   function automatic logic [KA-1:0] key_idx(input logic [KEY_W-1:0] k);
      logic [16:0] kx;
      kx = 17'(k);
      return kx[KA-1:0];
   endfunction

   state_type state_ff, state_in;

   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [PB-1:0]     prio_ff, prio_in;
   logic [KEY_W-1:0]  x_key_ff, x_key_in;
   logic [PB-1:0]     x_prio_ff, x_prio_in;
   logic [KEY_W-1:0]  left_key_ff, left_key_in;
   logic [PB-1:0]     left_prio_ff, left_prio_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              moved_ff, moved_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [KA-1:0]     clr_idx_ff, clr_idx_in;
   logic              clr_rsp_ff, clr_rsp_in;
   logic              direct_ff;
   logic [KEY_W-1:0]  top_key_ff;
   logic [PB-1:0]     top_prio_ff;

   logic               rsp_valid_ff;
   logic [STAT_W-1:0]  rsp_status_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic               rsp_top_valid_ff;
   logic [KEY_W-1:0]   rsp_top_key_ff;
   logic [PRIO_W-1:0]  rsp_top_prio_ff;

   logic          heap_we;
   logic [AW-1:0] heap_waddr;
   logic [EW-1:0] heap_wdata;
   logic [AW-1:0] heap_raddr;
   logic [EW-1:0] heap_rdata;
   logic          tbl_we;
   logic [KA-1:0] tbl_waddr;
   logic [TW-1:0] tbl_wdata;
   logic [KA-1:0] tbl_raddr;
   logic [TW-1:0] tbl_rdata;

   imhq_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap_ram (
      .clock   (clock),
      .wr_en   (heap_we),
      .wr_addr (heap_waddr),
      .wr_data (heap_wdata),
      .rd_addr (heap_raddr),
      .rd_data (heap_rdata)
   );

   imhq_ram #(.WIDTH(TW), .DEPTH(KEY_SPACE)) u_pos_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   logic [KEY_W-1:0] rd_key;
   logic [PB-1:0]    rd_prio;
   logic             tbl_v;
   logic [AW-1:0]    tbl_pos;
   logic             ins_full;
   logic             hit_pre;
   logic             found;
   logic [CW-1:0]    cnt_dec;
   logic             last_is_hole;
   logic             up_stop;
   logic             at_root;
   logic [AW-1:0]    pidx;
   logic [XW-1:0]    lft;
   logic [XW-1:0]    rgt;
   logic             has_l;
   logic             has_r;
   logic             pick_r;
   logic [KEY_W-1:0] c_key;
   logic [PB-1:0]    c_prio;
   logic [AW-1:0]    c_idx;
   logic             sink;
   logic             out_free;

   assign rd_key       = heap_rdata[EW-1:PB];
   assign rd_prio      = heap_rdata[PB-1:0];
   assign tbl_v        = tbl_rdata[AW];
   assign tbl_pos      = tbl_rdata[AW-1:0];
   assign ins_full     = cnt_ff >= CW'(HEAP_DEPTH);
   assign hit_pre      = tbl_v && (CW'(tbl_pos) < cnt_ff);
   assign found        = rd_key == key_ff;
   assign cnt_dec      = cnt_ff - CW'(1);
   assign last_is_hole = CW'(idx_ff) == cnt_dec;
   assign up_stop      = rd_prio <= x_prio_ff;
   assign at_root      = idx_ff == '0;
   assign pidx         = (idx_ff - AW'(1)) >> 1;
   assign lft          = {1'b0, idx_ff, 1'b1};
   assign rgt          = lft + XW'(1);
   assign has_l        = lft < XW'(cnt_ff);
   assign has_r        = rgt < XW'(cnt_ff);
   assign pick_r       = (state_ff == ST_DOWN_R) && (rd_prio < left_prio_ff);
   assign c_key        = (state_ff == ST_DOWN_L || pick_r) ? rd_key : left_key_ff;
   assign c_prio       = (state_ff == ST_DOWN_L || pick_r) ? rd_prio : left_prio_ff;
   assign c_idx        = pick_r ? rgt[AW-1:0] : lft[AW-1:0];
   assign sink         = x_prio_ff > c_prio;
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_idx_ff == KA'(KEY_SPACE - 1)) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (kind_ff) inside
               KIND_INSERT: begin
                  if (direct_ff) begin
                     state_in = key_ok(key_ff) ? ST_FIND : ST_DONE;
                  end else begin
                     state_in = ins_full ? ST_DONE : ST_UP;
                  end
               end
               KIND_UPDATE, KIND_REMOVE_KEY: begin
                  state_in = (direct_ff && key_ok(key_ff)) ? ST_FIND : ST_DONE;
               end
               KIND_REMOVE_MIN: begin
                  state_in = (cnt_ff == '0 || cnt_dec == '0) ? ST_DONE : ST_LAST;
               end
               KIND_CLEAR: state_in = ST_CLEAR;
               default:    state_in = ST_DONE;
            endcase
         end
         ST_FIND: begin
            if (hit_pre) begin
               state_in = ST_FOUND;
            end else if (kind_ff == KIND_INSERT && !ins_full) begin
               state_in = ST_UP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FOUND: begin
            if (found) begin
               case (kind_ff)
                  KIND_UPDATE:     state_in = ST_UP;
                  KIND_REMOVE_KEY: state_in = last_is_hole ? ST_DONE : ST_LAST;
                  default:         state_in = ST_DONE;
               endcase
            end else if (kind_ff == KIND_INSERT && !ins_full) begin
               state_in = ST_UP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_LAST: state_in = ST_UP;
         ST_UP: begin
            if (at_root) begin
               state_in = moved_ff ? ST_DONE : ST_DOWN;
            end else begin
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (up_stop) begin
               state_in = moved_ff ? ST_DONE : ST_DOWN;
            end else begin
               state_in = ST_UP;
            end
         end
         ST_DOWN: state_in = has_l ? ST_DOWN_L : ST_DONE;
         ST_DOWN_L: begin
            if (has_r) begin
               state_in = ST_DOWN_R;
            end else begin
               state_in = sink ? ST_DOWN : ST_DONE;
            end
         end
         ST_DOWN_R: state_in = sink ? ST_DOWN : ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      kind_in      = kind_ff;
      key_in       = key_ff;
      prio_in      = prio_ff;
      x_key_in     = x_key_ff;
      x_prio_in    = x_prio_ff;
      left_key_in  = left_key_ff;
      left_prio_in = left_prio_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      moved_in     = moved_ff;
      status_in    = status_ff;
      clr_idx_in   = clr_idx_ff;
      clr_rsp_in   = clr_rsp_ff;
      heap_we      = 1'b0;
      heap_waddr   = idx_ff;
      heap_wdata   = {x_key_ff, x_prio_ff};
      heap_raddr   = '0;
      tbl_we       = 1'b0;
      tbl_waddr    = key_idx(key_ff);
      tbl_wdata    = '0;
      tbl_raddr    = key_idx(key_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            tbl_we     = 1'b1;
            tbl_waddr  = clr_idx_ff;
            clr_idx_in = clr_idx_ff + KA'(1);
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               key_in    = req_key;
               prio_in   = PB'(req_priority_req);
               status_in = STAT_OK;
               moved_in  = 1'b0;
            end
         end
         ST_DECODE: begin
            case (kind_ff) inside
               KIND_INSERT: begin
                  if (direct_ff) begin
                     if (!key_ok(key_ff)) begin
                        status_in = STAT_NOT_FOUND;
                     end
                  end else if (ins_full) begin
                     status_in = STAT_FULL;
                  end else begin
                     x_key_in  = key_ff;
                     x_prio_in = prio_ff;
                     idx_in    = AW'(cnt_ff);
                     cnt_in    = cnt_ff + CW'(1);
                  end
               end
               KIND_UPDATE, KIND_REMOVE_KEY: begin
                  if (!direct_ff) begin
                     status_in = STAT_DIRECT_OFF;
                  end else if (!key_ok(key_ff)) begin
                     status_in = STAT_NOT_FOUND;
                  end
               end
               KIND_REMOVE_MIN: begin
                  if (cnt_ff == '0) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     cnt_in     = cnt_dec;
                     heap_raddr = AW'(cnt_dec);
                     idx_in     = '0;
                     if (direct_ff && key_ok(top_key_ff)) begin
                        tbl_we    = 1'b1;
                        tbl_waddr = key_idx(top_key_ff);
                     end
                  end
               end
               KIND_CLEAR: begin
                  cnt_in     = '0;
                  clr_idx_in = '0;
                  clr_rsp_in = 1'b1;
               end
               default: ;
            endcase
         end
         ST_FIND: begin
            heap_raddr = tbl_pos;
            idx_in     = tbl_pos;
            if (!hit_pre) begin
               if (kind_ff != KIND_INSERT) begin
                  status_in = STAT_NOT_FOUND;
               end else if (ins_full) begin
                  status_in = STAT_FULL;
               end else begin
                  x_key_in  = key_ff;
                  x_prio_in = prio_ff;
                  idx_in    = AW'(cnt_ff);
                  cnt_in    = cnt_ff + CW'(1);
               end
            end
         end
         ST_FOUND: begin
            if (found) begin
               case (kind_ff)
                  KIND_INSERT: status_in = STAT_DUPLICATE;
                  KIND_UPDATE: begin
                     x_key_in  = key_ff;
                     x_prio_in = prio_ff;
                  end
                  KIND_REMOVE_KEY: begin
                     tbl_we     = 1'b1;
                     cnt_in     = cnt_dec;
                     heap_raddr = AW'(cnt_dec);
                  end
                  default: ;
               endcase
            end else if (kind_ff != KIND_INSERT) begin
               status_in = STAT_NOT_FOUND;
            end else if (ins_full) begin
               status_in = STAT_FULL;
            end else begin
               x_key_in  = key_ff;
               x_prio_in = prio_ff;
               idx_in    = AW'(cnt_ff);
               cnt_in    = cnt_ff + CW'(1);
            end
         end
         ST_LAST: begin
            x_key_in  = rd_key;
            x_prio_in = rd_prio;
         end
         ST_UP: begin
            heap_raddr = pidx;
            if (at_root && moved_ff) begin
               heap_we = 1'b1;
            end
         end
         ST_UP_CMP: begin
            if (up_stop) begin
               heap_we = moved_ff;
            end else begin
               heap_we    = 1'b1;
               heap_wdata = heap_rdata;
               idx_in     = pidx;
               moved_in   = 1'b1;
            end
         end
         ST_DOWN: begin
            heap_raddr = lft[AW-1:0];
            if (!has_l) begin
               heap_we = 1'b1;
            end
         end
         ST_DOWN_L: begin
            left_key_in  = rd_key;
            left_prio_in = rd_prio;
            heap_raddr   = rgt[AW-1:0];
            if (!has_r) begin
               heap_we = 1'b1;
               if (sink) begin
                  heap_wdata = {c_key, c_prio};
                  idx_in     = c_idx;
               end
            end
         end
         ST_DOWN_R: begin
            heap_we = 1'b1;
            if (sink) begin
               heap_wdata = {c_key, c_prio};
               idx_in     = c_idx;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               clr_rsp_in = 1'b0;
            end
         end
         default: ;
      endcase

      // record the new position of every word with an in-range key moved in direct mode
      if (heap_we && direct_ff && key_ok(heap_wdata[EW-1:PB])) begin
         tbl_we    = 1'b1;
         tbl_waddr = key_idx(heap_wdata[EW-1:PB]);
         tbl_wdata = {1'b1, heap_waddr};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         moved_ff     <= 1'b0;
         clr_idx_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         direct_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         moved_ff   <= moved_in;
         clr_idx_ff <= clr_idx_in;
         clr_rsp_ff <= clr_rsp_in;
         if (csr_valid) begin
            direct_ff <= csr_direct_mode;
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_in_hold: begin
         kind_ff      <= kind_in;
         key_ff       <= key_in;
         prio_ff      <= prio_in;
         x_key_ff     <= x_key_in;
         x_prio_ff    <= x_prio_in;
         left_key_ff  <= left_key_in;
         left_prio_ff <= left_prio_in;
         idx_ff       <= idx_in;
         status_ff    <= status_in;
      end
      if (heap_we && heap_waddr == '0) begin
         top_key_ff  <= heap_wdata[EW-1:PB];
         top_prio_ff <= heap_wdata[PB-1:0];
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_status_ff    <= status_ff;
         rsp_total_ff     <= TOTAL_W'(cnt_ff);
         rsp_top_valid_ff <= cnt_ff != '0;
         rsp_top_key_ff   <= (cnt_ff != '0) ? top_key_ff : '0;
         rsp_top_prio_ff  <= (cnt_ff != '0) ? PRIO_W'(top_prio_ff) : '0;
      end
   end

   assign req_stall        = state_ff != ST_IDLE;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_total  = rsp_total_ff;
   assign rsp_top_valid    = rsp_top_valid_ff;
   assign rsp_top_key      = rsp_top_key_ff;
   assign rsp_top_priority = rsp_top_prio_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(HEAP_DEPTH))
      else $error("entry count beyond heap depth");

   a_child_in_heap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DOWN_L |-> CW'($past(heap_raddr)) < cnt_ff)
      else $error("sift-down read outside the heap");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_top_valid_ff) |-> (rsp_top_key_ff == '0 && rsp_top_prio_ff == '0))
      else $error("empty heap reports a top word");

endmodule
